/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication checked outside reset
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* rtl/sfr_pkg.sv */
package sfr_pkg;

   // Payload buffer sizing
   localparam int MAX_PAYLOAD = 32;
   localparam int RAM_ADDR_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   // Field widths
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 6;
   localparam int IDX_W       = 5;
   localparam int TIMER_W     = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 4;

   // CRC-16/ARC, reflected
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   // Input item kinds
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK,
      ST_TIMEOUT,
      ST_BAD_START,
      ST_BAD_END,
      ST_CRC,
      ST_BAD_LEN
   } status_type;

   // Work handed from the parser to the result sequencer
   typedef struct packed {
      logic                valid;
      logic                drain;        // read payload back from the buffer
      status_type          status;
      logic [BYTE_W-1:0]   frame_id;
      logic [LEN_W-1:0]    frame_length;
   } job_type;

   // Payload buffer write
   typedef struct packed {
      logic                  en;
      logic [RAM_ADDR_W-1:0] addr;
      logic [BYTE_W-1:0]     data;
   } ram_wr_type;

endpackage

/* rtl/sfr_payload_ram.sv */
module sfr_payload_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sfr_parser.sv */
module sfr_parser import sfr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,
   input  logic [0:0]            req_tuser,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  job_ready,
   output job_type               job,
   output ram_wr_type            ram_wr
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ID,
      PH_LEN,
      PH_DATA,
      PH_CRCLO,
      PH_CRCHI,
      PH_END
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [BYTE_W-1:0]    id_ff, id_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     count_ff, count_in;
   logic [15:0]          crc_ff, crc_in;
   logic [15:0]          crc_rx_ff, crc_rx_in;
   logic [TIMER_W-1:0]   timer_ff, timer_in;
   logic [BYTE_W-1:0]    start_ff, start_in;
   logic [BYTE_W-1:0]    end_ff, end_in;
   logic [TIMER_W-1:0]   timeout_ff, timeout_in;

   logic                 accept;
   logic [TIMER_W-1:0]   tick_count;
   logic [LEN_W-1:0]     count_next;
   logic [15:0]          crc_feed_b;

   // Bitwise CRC-16/ARC update over one byte
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Items are taken only while the result side has no job in hand
   assign req_tready = job_ready;
   assign accept     = req_tvalid && job_ready;
   assign crc_feed_b = crc_feed(crc_ff, req_tdata);
   assign tick_count = (timer_ff == '1) ? timer_ff : timer_ff + TIMER_W'(1);
   assign count_next = count_ff + LEN_W'(1);

   // Frame parser next state
   always_comb begin
      phase_in   = phase_ff;
      id_in      = id_ff;
      len_in     = len_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      crc_rx_in  = crc_rx_ff;
      timer_in   = timer_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      timeout_in = timeout_ff;
      job        = '0;
      ram_wr     = '0;

      job.frame_id     = id_ff;
      job.frame_length = len_ff;
      job.status       = ST_OK;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_START_MARKER:  start_in   = csr_data[BYTE_W-1:0];
            CSR_END_MARKER:    end_in     = csr_data[BYTE_W-1:0];
            CSR_TIMEOUT_TICKS: timeout_in = csr_data[TIMER_W-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         if (req_tuser[0] == FUNC_TICK) begin
            // wait-point timer, saturating
            timer_in = tick_count;
            if (tick_count >= timeout_ff) begin
               job.valid  = 1'b1;
               job.status = ST_TIMEOUT;
               phase_in   = PH_IDLE;
               timer_in   = '0;
            end
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (req_tdata != start_ff) begin
                     job.valid  = 1'b1;
                     job.status = ST_BAD_START;
                     timer_in   = '0;
                  end else begin
                     id_in     = '0;
                     len_in    = '0;
                     count_in  = '0;
                     crc_in    = '0;
                     crc_rx_in = '0;
                     timer_in  = '0;
                     phase_in  = PH_ID;
                  end
               end
               PH_ID: begin
                  id_in    = req_tdata;
                  crc_in   = crc_feed_b;
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  if (int'(req_tdata) > MAX_PAYLOAD) begin
                     job.valid  = 1'b1;
                     job.status = ST_BAD_LEN;
                     phase_in   = PH_IDLE;
                     timer_in   = '0;
                  end else begin
                     len_in   = req_tdata[LEN_W-1:0];
                     crc_in   = crc_feed_b;
                     count_in = '0;
                     timer_in = '0;
                     phase_in = (req_tdata != '0) ? PH_DATA : PH_CRCLO;
                  end
               end
               PH_DATA: begin
                  ram_wr.en   = 1'b1;
                  ram_wr.addr = count_ff[RAM_ADDR_W-1:0];
                  ram_wr.data = req_tdata;
                  crc_in      = crc_feed_b;
                  count_in    = count_next;
                  if (count_next >= len_ff) begin
                     timer_in = '0;
                     phase_in = PH_CRCLO;
                  end
               end
               PH_CRCLO: begin
                  crc_rx_in = {8'h00, req_tdata};
                  phase_in  = PH_CRCHI;
               end
               PH_CRCHI: begin
                  crc_rx_in = {req_tdata, crc_rx_ff[7:0]};
                  phase_in  = PH_END;
               end
               default: begin
                  // end byte is checked before the CRC
                  job.valid = 1'b1;
                  phase_in  = PH_IDLE;
                  timer_in  = '0;
                  if (req_tdata != end_ff) begin
                     job.status = ST_BAD_END;
                  end else if (crc_rx_ff != crc_ff) begin
                     job.status = ST_CRC;
                  end else begin
                     job.drain = (len_ff != '0);
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         id_ff      <= '0;
         len_ff     <= '0;
         count_ff   <= '0;
         crc_ff     <= '0;
         crc_rx_ff  <= '0;
         timer_ff   <= '0;
         start_ff   <= 8'hFF;
         end_ff     <= 8'hF7;
         timeout_ff <= TIMER_W'(200);
      end else begin
         phase_ff   <= phase_in;
         id_ff      <= id_in;
         len_ff     <= len_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         crc_rx_ff  <= crc_rx_in;
         timer_ff   <= timer_in;
         start_ff   <= start_in;
         end_ff     <= end_in;
         timeout_ff <= timeout_in;
      end
   end

endmodule

/* rtl/sfr_result_seq.sv */
module sfr_result_seq import sfr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  job_type                job,
   output logic                   job_ready,
   output logic                   rd_en,
   output logic [RAM_ADDR_W-1:0]  rd_addr,
   input  logic [BYTE_W-1:0]      rd_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   output logic                   rsp_tlast
);

   typedef enum logic [1:0] {
      OUT_IDLE,
      OUT_SINGLE,
      OUT_READ,
      OUT_EMIT
   } out_state_type;

   out_state_type       state_ff;
   job_type             job_ff;
   logic [LEN_W-1:0]    cnt_ff;
   logic                valid_ff;
   status_type          status_ff;
   logic [BYTE_W-1:0]   id_ff;
   logic [LEN_W-1:0]    len_ff;
   logic                dv_ff;
   logic [BYTE_W-1:0]   pb_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                last_ff;

   logic                slot_free;
   logic                out_load;
   logic [LEN_W-1:0]    cnt_next;

   // output register may be loaded when empty or being taken
   assign slot_free = !valid_ff || rsp_tready;
   assign out_load  = slot_free && (state_ff inside {OUT_SINGLE, OUT_EMIT});
   assign cnt_next  = cnt_ff + LEN_W'(1);
   assign job_ready = (state_ff == OUT_IDLE);
   assign rd_en     = (state_ff == OUT_READ);
   assign rd_addr   = cnt_ff[RAM_ADDR_W-1:0];

   // Result sequencer: one result for a lone status, read-then-emit per payload byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OUT_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (valid_ff && rsp_tready && !out_load) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            OUT_IDLE: begin
               if (job.valid) begin
                  job_ff   <= job;
                  cnt_ff   <= '0;
                  state_ff <= job.drain ? OUT_READ : OUT_SINGLE;
               end
            end
            OUT_SINGLE: begin
               if (slot_free) begin
                  valid_ff  <= 1'b1;
                  status_ff <= job_ff.status;
                  id_ff     <= job_ff.frame_id;
                  len_ff    <= job_ff.frame_length;
                  dv_ff     <= 1'b0;
                  pb_ff     <= '0;
                  idx_ff    <= '0;
                  last_ff   <= 1'b1;
                  state_ff  <= OUT_IDLE;
               end
            end
            OUT_READ: begin
               state_ff <= OUT_EMIT;
            end
            OUT_EMIT: begin
               if (slot_free) begin
                  valid_ff  <= 1'b1;
                  status_ff <= ST_OK;
                  id_ff     <= job_ff.frame_id;
                  len_ff    <= job_ff.frame_length;
                  dv_ff     <= 1'b1;
                  pb_ff     <= rd_data;
                  idx_ff    <= cnt_ff[IDX_W-1:0];
                  last_ff   <= (cnt_next == job_ff.frame_length);
                  cnt_ff    <= cnt_next;
                  state_ff  <= (cnt_next == job_ff.frame_length) ? OUT_IDLE : OUT_READ;
               end
            end
            default: state_ff <= OUT_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'b0, idx_ff, pb_ff, len_ff, id_ff};
   assign rsp_tuser  = {dv_ff, status_ff};
   assign rsp_tlast  = last_ff;

endmodule

/* rtl/serial_frame_receiver_crc16.sv */
// Path: a status result goes from the job register through OUT_SINGLE into the output register
// once the output slot is free; each payload result of a good frame goes through OUT_READ, then OUT_EMIT.
// Throughput: 1 item a cycle while no result is pending; a good frame blocks input while
// each payload byte is read and then emitted over the payload buffer port.
// Reset: synchronous, active high; parser registers and the sequencer state and valid flag
// return to defaults; the payload buffer is not cleared (only current-frame entries are read back).
`include "assert_macros.svh"

module serial_frame_receiver_crc16 import sfr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,   // [7:0] rx_byte
   input  logic [0:0]             req_tuser,   // [0] func
   // results
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [7:0] frame_id, [13:8] frame_length,
                                               // [21:14] payload_byte, [26:22] byte_index
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // [2:0] status, [3] data_valid
   output logic                   rsp_tlast,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   job_type               job;
   ram_wr_type            ram_wr;
   logic                  job_ready;
   logic                  rd_en;
   logic [RAM_ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0]     rd_data;

   assign csr_ready = 1'b1;

   sfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .job_ready  (job_ready),
      .job        (job),
      .ram_wr     (ram_wr)
   );

   sfr_payload_ram #(
      .DEPTH  (MAX_PAYLOAD),
      .WIDTH  (BYTE_W),
      .ADDR_W (RAM_ADDR_W)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sfr_result_seq u_result_seq (
      .clock      (clock),
      .reset      (reset),
      .job        (job),
      .job_ready  (job_ready),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // error results are lone items without payload
   `ASSERT_IMPLY(a_err_lone, rsp_tvalid && (rsp_tuser[2:0] != ST_OK), rsp_tlast && !rsp_tuser[3], "error result not a lone last item")
   // payload position lies inside the frame
   `ASSERT_IMPLY(a_idx_range, rsp_tvalid && rsp_tuser[3], rsp_tdata[26:22] < rsp_tdata[13:8], "byte index beyond frame length")
   // no input taken while a payload run is still being delivered
   `ASSERT_IMPLY(a_drain_blocks, rsp_tvalid && !rsp_tlast, !req_tready, "input taken during payload run")
   `ASSERT_CLK(a_len_range, !rsp_tvalid || (rsp_tdata[13:8] <= 6'(MAX_PAYLOAD)), "frame length above maximum")

endmodule
